// ----- rtl/core/acr_pkg.sv -----
// Package with the shared types, widths and codes of the box collision resolver.
package acr_pkg;

  localparam int CoordW  = 32;
  localparam int SizeW   = 24;
  localparam int ExtW    = 2 * SizeW;
  localparam int DiffW   = CoordW + 3;
  localparam int SumW    = SizeW + 1;
  localparam int MulInW  = SumW + 1;
  localparam int ProdW   = 2 * MulInW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [SizeW-1:0]  size_t;
  typedef logic        [ExtW-1:0]   extent_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic        [SumW-1:0]   span_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  typedef enum logic [2:0] {
    FACE_NONE   = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_TOP    = 3'd4
  } face_t;

  typedef enum logic [1:0] {
    MODE_PUSH_A,
    MODE_PUSH_B,
    MODE_RESTORE
  } mode_t;

  typedef struct packed {
    coord_t      a_pos_x;
    coord_t      a_pos_y;
    extent_t     a_extent;
    coord_t      a_prev_x;
    coord_t      a_prev_y;
    coord_t      b_pos_x;
    coord_t      b_pos_y;
    extent_t     b_extent;
    coord_t      b_prev_x;
    coord_t      b_prev_y;
    logic [1:0]  static_flags;
  } pair_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t apx;
    coord_t apy;
    coord_t bx;
    coord_t by;
    coord_t bpx;
    coord_t bpy;
  } boxpos_t;

  typedef struct packed {
    coord_t bot;
    coord_t top;
    coord_t right;
    coord_t left;
  } pushpos_t;

  typedef struct packed {
    mode_t    mode;
    diff_t    dx;
    diff_t    dy;
    span_t    w;
    span_t    h;
    pushpos_t push;
    boxpos_t  pos;
  } s1_t;

  typedef struct packed {
    mode_t    mode;
    logic     hit;
    prod_t    cw;
    prod_t    ch;
    pushpos_t push;
    boxpos_t  pos;
  } s2_t;

  typedef struct packed {
    logic   hit;
    face_t  face;
    coord_t a_new_x;
    coord_t a_new_y;
    coord_t b_new_x;
    coord_t b_new_y;
  } result_t;

endpackage

// ----- rtl/core/acr_in_if.sv -----
// Input channel interface: one box pair request with valid/ready handshake.
interface acr_in_if import acr_pkg::*; ();
  logic       valid;
  logic       ready;
  coord_t     a_pos_x;
  coord_t     a_pos_y;
  extent_t    a_extent;
  coord_t     a_prev_x;
  coord_t     a_prev_y;
  coord_t     b_pos_x;
  coord_t     b_pos_y;
  extent_t    b_extent;
  coord_t     b_prev_x;
  coord_t     b_prev_y;
  logic [1:0] static_flags;

  modport source (
    output valid, a_pos_x, a_pos_y, a_extent, a_prev_x, a_prev_y,
           b_pos_x, b_pos_y, b_extent, b_prev_x, b_prev_y, static_flags,
    input  ready
  );
  modport sink (
    input  valid, a_pos_x, a_pos_y, a_extent, a_prev_x, a_prev_y,
           b_pos_x, b_pos_y, b_extent, b_prev_x, b_prev_y, static_flags,
    output ready
  );
endinterface

// ----- rtl/core/acr_out_if.sv -----
// Result channel interface: hit, face and resolved corners with valid/ready handshake.
interface acr_out_if import acr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] face;
  coord_t     a_new_x;
  coord_t     a_new_y;
  coord_t     b_new_x;
  coord_t     b_new_y;

  modport source (
    output valid, hit, face, a_new_x, a_new_y, b_new_x, b_new_y,
    input  ready
  );
  modport sink (
    input  valid, hit, face, a_new_x, a_new_y, b_new_x, b_new_y,
    output ready
  );
endinterface

// ----- rtl/core/aabb_collision_resolve.sv -----
// Top level of the box collision resolver: three-stage pipeline between two channels.
//
// Each request carries two axis-aligned boxes A and B (corner, previous corner,
// packed width and height, static flag) and yields exactly one result: a hit
// flag, the face of the moving box relative to the other one (none, bottom,
// left, right, top) and the resolved corners of both boxes. Boxes that only
// touch count as a hit. When B is static (or both are), A is pushed flush
// against B; when only A is static, B is pushed against A; when neither is
// static, both boxes go back to their previous coordinate on the axis of the
// hit. Pushed coordinates wrap modulo 2^32. The block takes one request per
// clock while the result side keeps up, and each result passes through its
// three register stages: offset and span setup, the overlap test with the two
// 26x26-bit cross products, and the face decision feeding the output register.
// Each stage holds its own valid bit and fills whenever it is empty, so a
// stalled result side still lets requests flow in until all three stages are
// full, and nothing is dropped or repeated across stalls.
module aabb_collision_resolve import acr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  acr_in_if.sink    in_ch,
  acr_out_if.source out_ch
);

  pair_t   pair;
  logic    s1_valid;
  s1_t     s1_data;
  logic    s1_ready;
  logic    s2_valid;
  s2_t     s2_data;
  logic    s2_ready;
  result_t res;

  // Gather the request fields into one word for the first stage.
  always_comb begin
    pair.a_pos_x      = in_ch.a_pos_x;
    pair.a_pos_y      = in_ch.a_pos_y;
    pair.a_extent     = in_ch.a_extent;
    pair.a_prev_x     = in_ch.a_prev_x;
    pair.a_prev_y     = in_ch.a_prev_y;
    pair.b_pos_x      = in_ch.b_pos_x;
    pair.b_pos_y      = in_ch.b_pos_y;
    pair.b_extent     = in_ch.b_extent;
    pair.b_prev_x     = in_ch.b_prev_x;
    pair.b_prev_y     = in_ch.b_prev_y;
    pair.static_flags = in_ch.static_flags;
  end

  // Stage one picks the mover and forms the doubled centre offsets.
  acr_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_data   (pair),
    .in_ready  (in_ch.ready),
    .out_valid (s1_valid),
    .out_data  (s1_data),
    .out_ready (s1_ready)
  );

  // Stage two tests the overlap and forms the cross products.
  acr_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .in_ready  (s1_ready),
    .out_valid (s2_valid),
    .out_data  (s2_data),
    .out_ready (s2_ready)
  );

  // Stage three decides the face and holds the result for the sink.
  acr_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .in_ready  (s2_ready),
    .out_valid (out_ch.valid),
    .out_data  (res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.hit     = res.hit;
  assign out_ch.face    = res.face;
  assign out_ch.a_new_x = res.a_new_x;
  assign out_ch.a_new_y = res.a_new_y;
  assign out_ch.b_new_x = res.b_new_x;
  assign out_ch.b_new_y = res.b_new_y;

endmodule

// ----- rtl/core/acr_setup.sv -----
// First stage: mover selection, doubled centre offsets, summed size spans and push targets.
module acr_setup import acr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  pair_t in_data,
  output logic  in_ready,
  output logic  out_valid,
  output s1_t   out_data,
  input  logic  out_ready
);

  logic   v_r;
  s1_t    d_r;
  s1_t    d_nxt;
  logic   a_st;
  logic   b_st;
  logic   a_moves;
  coord_t m_x, m_y, o_x, o_y;
  size_t  m_w, m_h, o_w, o_h;
  diff_t  m_x2, m_y2, o_x2, o_y2;

  assign a_st    = in_data.static_flags[0];
  assign b_st    = in_data.static_flags[1];
  assign a_moves = b_st || !a_st;

  always_comb begin
    m_x = a_moves ? in_data.a_pos_x : in_data.b_pos_x;
    m_y = a_moves ? in_data.a_pos_y : in_data.b_pos_y;
    o_x = a_moves ? in_data.b_pos_x : in_data.a_pos_x;
    o_y = a_moves ? in_data.b_pos_y : in_data.a_pos_y;
    m_w = a_moves ? in_data.a_extent[ExtW-1:SizeW] : in_data.b_extent[ExtW-1:SizeW];
    m_h = a_moves ? in_data.a_extent[SizeW-1:0]    : in_data.b_extent[SizeW-1:0];
    o_w = a_moves ? in_data.b_extent[ExtW-1:SizeW] : in_data.a_extent[ExtW-1:SizeW];
    o_h = a_moves ? in_data.b_extent[SizeW-1:0]    : in_data.a_extent[SizeW-1:0];

    // Centre quantities are kept at twice their value so halves stay exact.
    m_x2 = {{2{m_x[CoordW-1]}}, m_x, 1'b0};
    m_y2 = {{2{m_y[CoordW-1]}}, m_y, 1'b0};
    o_x2 = {{2{o_x[CoordW-1]}}, o_x, 1'b0};
    o_y2 = {{2{o_y[CoordW-1]}}, o_y, 1'b0};

    if (b_st) begin
      d_nxt.mode = MODE_PUSH_A;
    end else if (a_st) begin
      d_nxt.mode = MODE_PUSH_B;
    end else begin
      d_nxt.mode = MODE_RESTORE;
    end
    d_nxt.dx = m_x2 + diff_t'({(DiffW-SizeW)'(0), m_w})
             - o_x2 - diff_t'({(DiffW-SizeW)'(0), o_w});
    d_nxt.dy = m_y2 + diff_t'({(DiffW-SizeW)'(0), m_h})
             - o_y2 - diff_t'({(DiffW-SizeW)'(0), o_h});
    d_nxt.w  = {1'b0, m_w} + {1'b0, o_w};
    d_nxt.h  = {1'b0, m_h} + {1'b0, o_h};

    // Flush positions against each face; these wrap like a plain 32-bit adder.
    d_nxt.push.bot   = o_y + coord_t'({(CoordW-SizeW)'(0), o_h});
    d_nxt.push.top   = o_y - coord_t'({(CoordW-SizeW)'(0), m_h});
    d_nxt.push.right = o_x + coord_t'({(CoordW-SizeW)'(0), o_w});
    d_nxt.push.left  = o_x - coord_t'({(CoordW-SizeW)'(0), m_w});

    d_nxt.pos.ax  = in_data.a_pos_x;
    d_nxt.pos.ay  = in_data.a_pos_y;
    d_nxt.pos.apx = in_data.a_prev_x;
    d_nxt.pos.apy = in_data.a_prev_y;
    d_nxt.pos.bx  = in_data.b_pos_x;
    d_nxt.pos.by  = in_data.b_pos_y;
    d_nxt.pos.bpx = in_data.b_prev_x;
    d_nxt.pos.bpy = in_data.b_prev_y;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ----- rtl/core/acr_mult.sv -----
// Second stage: overlap test and the two cross products that choose the face.
module acr_mult import acr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  s1_t  in_data,
  output logic in_ready,
  output logic out_valid,
  output s2_t  out_data,
  input  logic out_ready
);

  logic  v_r;
  s2_t   d_r;
  s2_t   d_nxt;
  diff_t w_ext;
  diff_t h_ext;
  logic signed [MulInW-1:0] w_op;
  logic signed [MulInW-1:0] h_op;
  logic signed [MulInW-1:0] dx_op;
  logic signed [MulInW-1:0] dy_op;

  always_comb begin
    w_ext = diff_t'({(DiffW-SumW)'(0), in_data.w});
    h_ext = diff_t'({(DiffW-SumW)'(0), in_data.h});
    w_op  = {1'b0, in_data.w};
    h_op  = {1'b0, in_data.h};
    // On a hit both offsets are bounded by a span, so the low bits carry them
    // exactly; without a hit the products are not used.
    dx_op = in_data.dx[MulInW-1:0];
    dy_op = in_data.dy[MulInW-1:0];

    d_nxt.mode = in_data.mode;
    d_nxt.hit  = (in_data.dx <= w_ext) && (in_data.dx >= -w_ext) &&
                 (in_data.dy <= h_ext) && (in_data.dy >= -h_ext);
    d_nxt.cw   = prod_t'(w_op) * prod_t'(dy_op);
    d_nxt.ch   = prod_t'(h_op) * prod_t'(dx_op);
    d_nxt.push = in_data.push;
    d_nxt.pos  = in_data.pos;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ----- rtl/core/acr_resolve.sv -----
// Third stage: face decision and resolved corners, held in the output register.
module acr_resolve import acr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  s2_t     in_data,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    v_r;
  result_t d_r;
  result_t d_nxt;
  face_t   face;
  prod_t   neg_ch;
  logic    push_y;
  logic    push_x;
  coord_t  new_y;
  coord_t  new_x;

  always_comb begin
    neg_ch = -in_data.ch;
    if (!in_data.hit) begin
      face = FACE_NONE;
    end else if (in_data.cw > in_data.ch) begin
      face = (in_data.cw > neg_ch) ? FACE_BOTTOM : FACE_LEFT;
    end else begin
      face = (in_data.cw > neg_ch) ? FACE_RIGHT : FACE_TOP;
    end

    push_y = (face == FACE_BOTTOM) || (face == FACE_TOP);
    push_x = (face == FACE_LEFT) || (face == FACE_RIGHT);
    new_y  = (face == FACE_BOTTOM) ? in_data.push.bot : in_data.push.top;
    new_x  = (face == FACE_RIGHT) ? in_data.push.right : in_data.push.left;

    d_nxt.hit     = in_data.hit;
    d_nxt.face    = face;
    d_nxt.a_new_x = in_data.pos.ax;
    d_nxt.a_new_y = in_data.pos.ay;
    d_nxt.b_new_x = in_data.pos.bx;
    d_nxt.b_new_y = in_data.pos.by;

    case (in_data.mode)
      MODE_PUSH_A: begin
        if (push_y) d_nxt.a_new_y = new_y;
        if (push_x) d_nxt.a_new_x = new_x;
      end
      MODE_PUSH_B: begin
        if (push_y) d_nxt.b_new_y = new_y;
        if (push_x) d_nxt.b_new_x = new_x;
      end
      MODE_RESTORE: begin
        if (push_y) begin
          d_nxt.a_new_y = in_data.pos.apy;
          d_nxt.b_new_y = in_data.pos.bpy;
        end
        if (push_x) begin
          d_nxt.a_new_x = in_data.pos.apx;
          d_nxt.b_new_x = in_data.pos.bpx;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ----- rtl/core/acr_checker.sv -----
// Port-level checker for the box collision resolver, bound to the top level.
module acr_checker import acr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hit,
  input logic [2:0] face,
  input coord_t     a_new_x,
  input coord_t     a_new_y,
  input coord_t     b_new_x,
  input coord_t     b_new_y
);

  // A result reports a hit exactly when it names a face.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (hit == (face != FACE_NONE)))
    else $error("hit flag disagrees with face");

  // A result that is not taken stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({hit, face, a_new_x, a_new_y, b_new_x, b_new_y}))
    else $error("stalled result changed");

  // With no result waiting, the pipeline is never full.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // A request reaches the output through the setup, product and face stages when the sink keeps up.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind aabb_collision_resolve acr_checker u_acr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit       (out_ch.hit),
  .face      (out_ch.face),
  .a_new_x   (out_ch.a_new_x),
  .a_new_y   (out_ch.a_new_y),
  .b_new_x   (out_ch.b_new_x),
  .b_new_y   (out_ch.b_new_y)
);
